[rtl/scfb_pkg.sv]
// Shared types, constants and frame/CRC helper functions for the command frame builder.
package scfb_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int KIND_W    = 2;
   localparam int STATION_W = 16;
   localparam int SECONDS_W = 32;
   localparam int BYTE_W    = 8;
   localparam int POS_W     = 5;
   localparam int CRC_W     = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_SEND_CFG = 2'd0,
      KIND_DATA_ON  = 2'd1,
      KIND_DATA_OFF = 2'd2,
      KIND_INVALID  = 2'd3
   } kind_type;

   localparam logic [BYTE_W-1:0] SYNC_HI         = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_LO         = 8'h41;
   localparam logic [BYTE_W-1:0] FRAME_SIZE_BYTE = 8'd18;
   localparam logic [BYTE_W-1:0] CMD_SEND_CFG    = 8'h05;
   localparam logic [BYTE_W-1:0] CMD_DATA_ON     = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_DATA_OFF    = 8'h01;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam logic [POS_W-1:0] POS_SYNC_HI  = 5'd0;
   localparam logic [POS_W-1:0] POS_SYNC_LO  = 5'd1;
   localparam logic [POS_W-1:0] POS_SIZE_LO  = 5'd3;
   localparam logic [POS_W-1:0] POS_ID_HI    = 5'd4;
   localparam logic [POS_W-1:0] POS_ID_LO    = 5'd5;
   localparam logic [POS_W-1:0] POS_SEC_3    = 5'd6;
   localparam logic [POS_W-1:0] POS_SEC_2    = 5'd7;
   localparam logic [POS_W-1:0] POS_SEC_1    = 5'd8;
   localparam logic [POS_W-1:0] POS_SEC_0    = 5'd9;
   localparam logic [POS_W-1:0] POS_CMD_LO   = 5'd15;
   localparam logic [POS_W-1:0] POS_CRC_HI   = 5'd16;
   localparam logic [POS_W-1:0] POS_LAST     = 5'd17;

   typedef struct packed {
      kind_type               cmd;
      logic [STATION_W-1:0]   station;
      logic [SECONDS_W-1:0]   seconds;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   function automatic logic [BYTE_W-1:0] cmd_byte(input kind_type cmd);
      logic [BYTE_W-1:0] b;
      unique case (cmd)
         KIND_SEND_CFG: b = CMD_SEND_CFG;
         KIND_DATA_ON:  b = CMD_DATA_ON;
         KIND_DATA_OFF: b = CMD_DATA_OFF;
         default:       b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] body_byte(input logic [POS_W-1:0] pos,
                                                   input entry_type e);
      logic [BYTE_W-1:0] b;
      unique case (pos)
         POS_SYNC_HI: b = SYNC_HI;
         POS_SYNC_LO: b = SYNC_LO;
         POS_SIZE_LO: b = FRAME_SIZE_BYTE;
         POS_ID_HI:   b = e.station[15:8];
         POS_ID_LO:   b = e.station[7:0];
         POS_SEC_3:   b = e.seconds[31:24];
         POS_SEC_2:   b = e.seconds[23:16];
         POS_SEC_1:   b = e.seconds[15:8];
         POS_SEC_0:   b = e.seconds[7:0];
         POS_CMD_LO:  b = cmd_byte(e.cmd);
         default:     b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_i,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/scfb_front.sv]
// Front end: takes request transfers, drops invalid kinds, forms queue entries.
module scfb_front (
   input  logic                           req_tvalid,
   input  logic                           queue_full,
   output logic                           req_tready,
   input  logic [scfb_pkg::KIND_W-1:0]    req_kind,
   input  logic [scfb_pkg::STATION_W-1:0] req_station,
   input  logic [scfb_pkg::SECONDS_W-1:0] req_seconds,
   output scfb_pkg::push_type             push
);
   import scfb_pkg::*;

   kind_type kind;

   assign kind       = kind_type'(req_kind);
   assign req_tready = !queue_full;

   always_comb begin
      push.valid         = req_tvalid && !queue_full && (kind != KIND_INVALID);
      push.entry.cmd     = kind;
      push.entry.station = req_station;
      push.entry.seconds = req_seconds;
   end

endmodule

[rtl/scfb_queue.sv]
// Small register FIFO of decoded requests between front and back ends.
module scfb_queue #(
   parameter int DEPTH = scfb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  scfb_pkg::push_type push,
   input  logic               pop,
   output logic               full,
   output scfb_pkg::head_type head
);
   import scfb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_MAX);
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

[rtl/scfb_back.sv]
// Back end: frame serializer, running CRC, output reg; a byte per cycle unless stalled.
module scfb_back (
   input  logic                         clock,
   input  logic                         reset,
   input  scfb_pkg::head_type           head,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [scfb_pkg::BYTE_W-1:0]  rsp_byte,
   output logic [scfb_pkg::POS_W-1:0]   rsp_pos,
   output logic                         rsp_tlast
);
   import scfb_pkg::*;

   logic                busy_ff,  busy_in;
   logic [POS_W-1:0]    pos_ff,   pos_in;
   logic [CRC_W-1:0]    crc_ff,   crc_in;
   entry_type           entry_ff, entry_in;
   logic                ov_ff,    ov_in;
   logic [BYTE_W-1:0]   obyte_ff, obyte_in;
   logic [POS_W-1:0]    opos_ff,  opos_in;
   logic                olast_ff, olast_in;
   logic                can_emit;
   logic [BYTE_W-1:0]   cur_byte;

   assign can_emit = !ov_ff || rsp_tready;

   always_comb begin
      if (pos_ff < POS_CRC_HI) begin
         cur_byte = body_byte(pos_ff, entry_ff);
      end else if (pos_ff == POS_CRC_HI) begin
         cur_byte = crc_ff[15:8];
      end else begin
         cur_byte = crc_ff[7:0];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      entry_in = entry_ff;
      ov_in    = ov_ff;
      obyte_in = obyte_ff;
      opos_in  = opos_ff;
      olast_in = olast_ff;
      pop      = 1'b0;

      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end

      if (busy_ff && can_emit) begin
         ov_in    = 1'b1;
         obyte_in = cur_byte;
         opos_in  = pos_ff;
         olast_in = (pos_ff == POS_LAST);
         if (pos_ff < POS_CRC_HI) begin
            crc_in = crc_byte(crc_ff, cur_byte);
         end
         if (pos_ff == POS_LAST) begin
            busy_in = 1'b0;
            if (head.valid) begin
               pop      = 1'b1;
               busy_in  = 1'b1;
               pos_in   = '0;
               crc_in   = CRC_INIT;
               entry_in = head.entry;
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end else if (!busy_ff && head.valid) begin
         pop      = 1'b1;
         busy_in  = 1'b1;
         pos_in   = '0;
         crc_in   = CRC_INIT;
         entry_in = head.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
         crc_ff  <= CRC_INIT;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      obyte_ff <= obyte_in;
      opos_ff  <= opos_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_byte   = obyte_ff;
   assign rsp_pos    = opos_ff;
   assign rsp_tlast  = olast_ff;

endmodule

[rtl/synchrophasor_command_frame_builder.sv]
// Command frame builder: request stream in, 18-byte command frame byte stream out.
//
// Usage:
//   req channel: one transfer per command request. req_tuser carries the
//   command kind (0 send config, 1 data on, 2 data off, 3 invalid); kind 3
//   is consumed and produces nothing. req_tdata carries station id and
//   second-of-century.
//   rsp channel: 18 transfers per valid request, one frame byte each, with
//   its offset in rsp_tdata and rsp_tlast on the CRC low byte.
//   An idle block passes a request through the queue and the back end's
//   frame registers to the output register. Throughput: one byte per cycle
//   while the receiver does not stall, set by the back end's serializer;
//   the request queue lets the next frame start right after byte 17.
//   Requests are taken while the queue (QUEUE_DEPTH entries) has room.
//   When the receiver stalls, the output register holds its byte and the
//   serializer waits; requests still fill the queue until it is full.
//   Reset (synchronous) empties the queue, drops any frame in progress and
//   clears rsp_tvalid.
module synchrophasor_command_frame_builder #(
   parameter int QUEUE_DEPTH = scfb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] kind
   input  logic [47:0] req_tdata,   // [15:0] station_id, [47:16] second_of_century
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] frame_byte, [12:8] byte_position, [15:13] zero
   output logic        rsp_tlast    // last_byte
);
   import scfb_pkg::*;

   push_type          push;
   head_type          head;
   logic              queue_full;
   logic              pop;
   logic [BYTE_W-1:0] rsp_byte;
   logic [POS_W-1:0]  rsp_pos;

   scfb_front u_front (
      .req_tvalid  (req_tvalid),
      .queue_full  (queue_full),
      .req_tready  (req_tready),
      .req_kind    (req_tuser),
      .req_station (req_tdata[15:0]),
      .req_seconds (req_tdata[47:16]),
      .push        (push)
   );

   scfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   scfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_byte),
      .rsp_pos    (rsp_pos),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_pos, rsp_byte};

endmodule

[rtl/scfb_checker.sv]
// Port-level checker for the command frame builder, bound to the top level.
module scfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transfer changed while stalled");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[12:8] == 5'd17)) && (rsp_tdata[12:8] <= 5'd17))
      else $error("tlast/position mismatch");

   a_next_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast
      |=> rsp_tvalid && (rsp_tdata[12:8] == $past(rsp_tdata[12:8]) + 5'd1))
      else $error("frame bytes not contiguous");

   a_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[12:8] == 5'd0) |-> rsp_tdata[7:0] == 8'hAA)
      else $error("frame does not start with sync byte");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

endmodule

bind synchrophasor_command_frame_builder scfb_checker u_scfb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
